@@ rtl/core/urx_pkg.sv @@
package urx_pkg;

   localparam int FifoDepth = 16;
   localparam int AddrW     = $clog2(FifoDepth);
   localparam int PtrW      = AddrW + 1;
   localparam int TpbW      = 10;
   localparam int FillW     = 5;

   localparam logic [TpbW-1:0] TpbReset = 10'd38;

   localparam logic [3:0] PhaseStart = 4'd0;
   localparam logic [3:0] PhaseStop  = 4'd9;

   typedef struct packed {
      logic kind;
      logic line_level;
   } req_type;

   typedef struct packed {
      logic             byte_valid;
      logic [7:0]       byte_out;
      logic [FillW-1:0] fill_count;
      logic             framing_error;
      logic             overflow;
   } rsp_type;

   // stop bit sampled on this tick
   typedef struct packed {
      logic       done;
      logic       level;
      logic [7:0] data;
   } frm_evt_type;

   typedef struct packed {
      logic             byte_valid;
      logic [FillW-1:0] fill_count;
      logic             framing_error;
      logic             overflow;
   } fifo_sts_type;

endpackage

@@ rtl/core/urx_frame.sv @@
module urx_frame (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tick_en,
   input  logic                      line_level,
   input  logic [urx_pkg::TpbW-1:0]  tpb,
   output urx_pkg::frm_evt_type      evt
);
   import urx_pkg::*;

   logic            busy_ff,  busy_in;
   logic [3:0]      bit_ff,   bit_in;
   logic [7:0]      shift_ff, shift_in;
   logic [TpbW-1:0] tick_ff,  tick_in;
   logic [TpbW-1:0] wait_len;
   logic [TpbW-1:0] tick_nxt;
   logic            hit;

   always_comb begin
      wait_len = (bit_ff == PhaseStart) ? {1'b0, tpb[TpbW-1:1]} : tpb;
      tick_nxt = tick_ff + {{(TpbW-1){1'b0}}, 1'b1};
      hit      = tick_nxt >= wait_len;
      busy_in  = busy_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      tick_in  = tick_ff;
      evt      = '{done: 1'b0, level: line_level, data: shift_ff};
      if (tick_en) begin
         if (!busy_ff) begin
            if (!line_level) begin
               busy_in  = 1'b1;
               bit_in   = PhaseStart;
               shift_in = 8'd0;
               tick_in  = '0;
            end
         end else if (hit) begin
            tick_in = '0;
            if (bit_ff == PhaseStart) begin
               bit_in = 4'd1;
            end else if (bit_ff < PhaseStop) begin
               shift_in = {line_level, shift_ff[7:1]};
               bit_in   = bit_ff + 4'd1;
            end else begin
               evt.done = 1'b1;
               busy_in  = 1'b0;
               bit_in   = PhaseStart;
            end
         end else begin
            tick_in = tick_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         bit_ff   <= PhaseStart;
         shift_ff <= 8'd0;
         tick_ff  <= '0;
      end else begin
         busy_ff  <= busy_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         tick_ff  <= tick_in;
      end
   end

endmodule

@@ rtl/core/urx_fifo.sv @@
module urx_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  pop,
   input  urx_pkg::frm_evt_type  evt,
   output urx_pkg::fifo_sts_type sts,
   output logic [7:0]            byte_ff
);
   import urx_pkg::*;

   logic [7:0]      mem [FifoDepth];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [PtrW-1:0] fill_now, fill_nxt;
   logic            pop_ok, push_ok;

   always_comb begin
      fill_now  = wr_ff - rd_ff;
      pop_ok    = pop && (fill_now != '0);
      push_ok   = evt.done && evt.level && (fill_now < PtrW'(FifoDepth));
      wr_in     = push_ok ? wr_ff + {{(PtrW-1){1'b0}}, 1'b1} : wr_ff;
      rd_in     = pop_ok  ? rd_ff + {{(PtrW-1){1'b0}}, 1'b1} : rd_ff;
      fill_nxt  = wr_in - rd_in;
      sts.byte_valid    = pop_ok;
      sts.fill_count    = FillW'(fill_nxt);
      sts.framing_error = evt.done && !evt.level;
      sts.overflow      = evt.done && evt.level && !push_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[wr_ff[AddrW-1:0]] <= evt.data;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ok) begin
         byte_ff <= mem[rd_ff[AddrW-1:0]];
      end else if (accept) begin
         byte_ff <= 8'd0;
      end
   end

endmodule

@@ rtl/core/uart_rx_8n1_with_fifo.sv @@
// channel   dir  payload         handshake
// req       in   req_type        req_valid / req_stall
// rsp       out  rsp_type        rsp_valid / rsp_stall
// csr       in   ticks_per_bit   csr_wr_en / csr_wr_data
//
// One request per cycle while req_stall is low; its response is registered into the output register in the next cycle.
// The receiver/FIFO update feeding that register is combinational.
// Synchronous reset: receiver idle, FIFO empty, ticks_per_bit = 38.
// req_stall is high only while a response is held and rsp_stall is high.
module uart_rx_8n1_with_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  urx_pkg::req_type         req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output urx_pkg::rsp_type         rsp_data,
   input  logic                     csr_wr_en,
   input  logic [urx_pkg::TpbW-1:0] csr_wr_data
);
   import urx_pkg::*;

   logic            accept;
   logic [TpbW-1:0] tpb_ff;
   logic            vld_ff, vld_in;
   frm_evt_type     evt;
   fifo_sts_type    sts;
   fifo_sts_type    sts_ff;
   logic [7:0]      byte_ff;

   assign req_stall = vld_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign vld_in    = accept || (vld_ff && rsp_stall);

   urx_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .tick_en    (accept && !req_data.kind),
      .line_level (req_data.line_level),
      .tpb        (tpb_ff),
      .evt        (evt)
   );

   urx_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .pop     (accept && req_data.kind),
      .evt     (evt),
      .sts     (sts),
      .byte_ff (byte_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tpb_ff <= TpbReset;
         vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tpb_ff <= csr_wr_data;
         end
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sts_ff <= sts;
      end
   end

   assign rsp_valid              = vld_ff;
   assign rsp_data.byte_valid    = sts_ff.byte_valid;
   assign rsp_data.byte_out      = byte_ff;
   assign rsp_data.fill_count    = sts_ff.fill_count;
   assign rsp_data.framing_error = sts_ff.framing_error;
   assign rsp_data.overflow      = sts_ff.overflow;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fill_count <= FillW'(FifoDepth)))
      else $error("fill count above depth");

   a_err_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.framing_error && rsp_data.overflow))
      else $error("framing error and overflow together");

   a_tick_no_byte: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_data.kind) |=> (rsp_valid && !rsp_data.byte_valid
                                      && rsp_data.byte_out == 8'd0))
      else $error("tick returned a byte");

   a_pop_no_err: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind) |=> (!rsp_data.framing_error && !rsp_data.overflow))
      else $error("pop flagged a receive error");
`endif

endmodule

@@ sim/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import urx_pkg::*;

   localparam int IdleLimit = 2000;

   class rx_shadow;
      logic [TpbW-1:0] bit_time;
      logic            busy;
      logic [3:0]      phase;
      logic [7:0]      shreg;
      logic [TpbW-1:0] tcnt;
      logic [7:0]      mem [FifoDepth];
      logic [PtrW-1:0] wptr;
      logic [PtrW-1:0] rptr;
      rsp_type         rsp_due [$];
      int              errors;

      function new();
         bit_time = TpbReset;
         busy     = 1'b0;
         phase    = PhaseStart;
         shreg    = '0;
         tcnt     = '0;
         wptr     = '0;
         rptr     = '0;
         errors   = 0;
      endfunction

      function void set_bit_time(input logic [TpbW-1:0] v);
         bit_time = v;
      endfunction

      function void note_request(input req_type r);
         rsp_type         e;
         logic [TpbW-1:0] wait_len;
         logic [PtrW-1:0] fill;
         e = '0;
         if (r.kind) begin
            if (wptr != rptr) begin
               e.byte_valid = 1'b1;
               e.byte_out   = mem[rptr[AddrW-1:0]];
               rptr         = rptr + 1'b1;
            end
         end else if (!busy) begin
            if (!r.line_level) begin
               busy  = 1'b1;
               phase = PhaseStart;
               shreg = '0;
               tcnt  = '0;
            end
         end else begin
            wait_len = (phase == PhaseStart) ? (bit_time >> 1) : bit_time;
            tcnt = tcnt + 1'b1;
            if (tcnt >= wait_len) begin
               tcnt = '0;
               if (phase == PhaseStart) begin
                  phase = phase + 1'b1;
               end else if (phase < PhaseStop) begin
                  shreg = {r.line_level, shreg[7:1]};
                  phase = phase + 1'b1;
               end else begin
                  fill = wptr - rptr;
                  if (r.line_level) begin
                     if (fill < FifoDepth) begin
                        mem[wptr[AddrW-1:0]] = shreg;
                        wptr = wptr + 1'b1;
                     end else begin
                        e.overflow = 1'b1;
                     end
                  end else begin
                     e.framing_error = 1'b1;
                  end
                  busy  = 1'b0;
                  phase = PhaseStart;
               end
            end
         end
         fill = wptr - rptr;
         e.fill_count = fill;
         rsp_due.push_back(e);
      endfunction

      function void check_response(input rsp_type a);
         rsp_type e;
         if (rsp_due.size() == 0) begin
            $error("unexpected response %p", a);
            errors++;
            return;
         end
         e = rsp_due.pop_front();
         if (a.byte_valid !== e.byte_valid) begin
            $error("byte_valid: expected %0d, got %0d", e.byte_valid, a.byte_valid);
            errors++;
         end
         if (a.byte_out !== e.byte_out) begin
            $error("byte_out: expected %0h, got %0h", e.byte_out, a.byte_out);
            errors++;
         end
         if (a.fill_count !== e.fill_count) begin
            $error("fill_count: expected %0d, got %0d", e.fill_count, a.fill_count);
            errors++;
         end
         if (a.framing_error !== e.framing_error) begin
            $error("framing_error: expected %0d, got %0d", e.framing_error, a.framing_error);
            errors++;
         end
         if (a.overflow !== e.overflow) begin
            $error("overflow: expected %0d, got %0d", e.overflow, a.overflow);
            errors++;
         end
      endfunction
   endclass

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_type         req_data    = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_type         rsp_data;
   logic            csr_wr_en   = 1'b0;
   logic [TpbW-1:0] csr_wr_data = '0;

   rx_shadow sb = new();
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int n_sent        = 0;
   int idle_cycles   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   uart_rx_8n1_with_fifo u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_data);
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   task automatic send_req(input logic is_pop, input logic lvl);
      req_type r;
      r.kind       = is_pop;
      r.line_level = lvl;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(r);
      n_sent++;
   endtask

   task automatic pop_byte();
      send_req(1'b1, 1'($urandom_range(1)));
   endtask

   // one 8N1 frame, each bit centered on the receiver's sample point
   task automatic send_frame(input logic [7:0] data, input logic stop_level,
                             input int pop_pct, input bit jitter);
      int   h;
      int   m;
      int   len;
      logic lvl;
      m = (sb.bit_time > 1) ? sb.bit_time : 1;
      h = ((sb.bit_time >> 1) > 1) ? (sb.bit_time >> 1) : 1;
      for (int k = 0; k < 10; k++) begin
         lvl = (k == 0) ? 1'b0 : (k == 9) ? stop_level : data[k-1];
         len = (k == 0) ? h + m - m / 2 : m;
         if (jitter) len = len + $urandom_range(2) - 1;
         repeat (len) begin
            if ($urandom_range(99) < pop_pct) pop_byte();
            send_req(1'b0, lvl);
         end
      end
      repeat ($urandom_range(m)) send_req(1'b0, 1'b1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.rsp_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_bit_time(input logic [TpbW-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.set_bit_time(v);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_mixed(input int count);
      int stop_at;
      int pick;
      stop_at = n_sent + count;
      while (n_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_frame(8'($urandom_range(255)), $urandom_range(9) != 0, 12, 1'b0);
         end else if (pick < 80) begin
            send_frame(8'($urandom_range(255)), 1'($urandom_range(1)), 12, 1'b1);
         end else if (pick < 90) begin
            repeat ($urandom_range(8, 1)) pop_byte();
         end else begin
            repeat ($urandom_range(40, 1)) begin
               send_req($urandom_range(3) == 0, 1'($urandom_range(1)));
            end
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      stall_pct     = 45;
      write_bit_time(10'd1);
      pop_byte();
      send_frame(8'hFF, 1'b1, 0, 1'b0);
      send_frame(8'h00, 1'b0, 0, 1'b0);
      repeat (3) pop_byte();

      // fill past capacity so the last frames overflow
      write_bit_time(10'd0);
      repeat (FifoDepth + 2) send_frame(8'($urandom_range(255)), 1'b1, 0, 1'b0);
      repeat (FifoDepth + 2) pop_byte();

      write_bit_time(TpbW'($urandom_range(9, 4)));
      run_mixed(170);

      send_idle_pct = 45;
      stall_pct     = 10;
      write_bit_time(TpbW'($urandom_range(12, 4)));
      run_mixed(170);

      send_idle_pct = 0;
      stall_pct     = 0;
      write_bit_time(10'd4);
      run_mixed(130);

      // long bit time: start bit and part of the half-bit wait
      write_bit_time(10'd1023);
      repeat (40) send_req(1'b0, 1'b0);
      repeat (3) pop_byte();

      drain();
      repeat (5) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

@@ uart_rx_8n1_with_fifo.f @@
rtl/core/urx_pkg.sv
rtl/core/urx_frame.sv
rtl/core/urx_fifo.sv
rtl/core/uart_rx_8n1_with_fifo.sv
sim/tb_top.sv
